### rtl/ptlca_pkg.sv
// ---------------------------------------------------------------------------
// ptlca_pkg: shared definitions for the parent tree ancestor engine
// widths, function and status codes, and the tree memory request/response
// ---------------------------------------------------------------------------
`default_nettype none

package ptlca_pkg;

  // node ids and tree size
  localparam int ID_W      = 10;
  localparam int MAX_NODES = 2 ** ID_W;
  localparam int CNT_W     = 3;
  localparam int FUNC_W    = 2;
  localparam int STATUS_W  = 3;

  // ancestor chain buffers
  localparam int MAX_DEPTH   = 63;
  localparam int CHAIN_SLOTS = 64;
  localparam int CHAIN_AW    = 6;

  // function codes
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LIST   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_COMMON = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REJECT     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_MEMBER = 3'd2;
  localparam logic [STATUS_W-1:0] ST_A_NOT      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_B_NOT      = 3'd4;
  localparam logic [STATUS_W-1:0] ST_BOTH_NOT   = 3'd5;
  localparam logic [STATUS_W-1:0] ST_NO_COMMON  = 3'd6;
  localparam logic [STATUS_W-1:0] ST_TOO_DEEP   = 3'd7;

  // requests into the tree memories
  typedef struct packed {
    logic [ID_W-1:0]  p_raddr;
    logic [ID_W-1:0]  c_raddr;
    logic             p_we;
    logic [ID_W-1:0]  p_waddr;
    logic [ID_W-1:0]  p_wdata;
    logic             c_we;
    logic [ID_W-1:0]  c_waddr;
    logic [CNT_W-1:0] c_wdata;
  } tree_req_t;

  // registered read data and clearing status
  typedef struct packed {
    logic [ID_W-1:0]  p_rdata;
    logic [CNT_W-1:0] c_rdata;
    logic             busy;
  } tree_rsp_t;

endpackage

`default_nettype wire

### rtl/ptlca_in_if.sv
// ---------------------------------------------------------------------------
// ptlca_in_if: command channel
// valid/ready handshake carrying one command per transfer
// ---------------------------------------------------------------------------
`default_nettype none

interface ptlca_in_if;
  import ptlca_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [ID_W-1:0]   node_a;
  logic [ID_W-1:0]   node_b;

  modport source (output valid, func, node_a, node_b, input ready);
  modport sink   (input valid, func, node_a, node_b, output ready);
endinterface

`default_nettype wire

### rtl/ptlca_out_if.sv
// ---------------------------------------------------------------------------
// ptlca_out_if: result channel
// valid/ready handshake carrying one result per transfer
// ---------------------------------------------------------------------------
`default_nettype none

interface ptlca_out_if;
  import ptlca_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     ancestor;
  logic                last;

  modport source (output valid, status, ancestor, last, input ready);
  modport sink   (input valid, status, ancestor, last, output ready);
endinterface

`default_nettype wire

### rtl/ptlca_tree_mem.sv
// ---------------------------------------------------------------------------
// ptlca_tree_mem: parent and child count memories
// one read and one write port each, registered reads, and a
// clearing sweep over every entry after reset
// ---------------------------------------------------------------------------
`default_nettype none

module ptlca_tree_mem (
  input  wire                       clk,
  input  wire                       rst,
  input  wire ptlca_pkg::tree_req_t req,
  output ptlca_pkg::tree_rsp_t      rsp
);
  import ptlca_pkg::*;

  logic [ID_W-1:0]  parent_mem [MAX_NODES];
  logic [CNT_W-1:0] count_mem  [MAX_NODES];

  logic             clr_busy;
  logic [ID_W-1:0]  clr_addr;
  logic [ID_W-1:0]  p_rdata;
  logic [CNT_W-1:0] c_rdata;

  // clearing sweep, one entry per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + ID_W'(1);
      if (clr_addr == ID_W'(MAX_NODES - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  // write ports and registered reads
  always_ff @(posedge clk) begin
    if (clr_busy) begin
      parent_mem[clr_addr] <= '0;
      count_mem[clr_addr]  <= '0;
    end else begin
      if (req.p_we) begin
        parent_mem[req.p_waddr] <= req.p_wdata;
      end
      if (req.c_we) begin
        count_mem[req.c_waddr] <= req.c_wdata;
      end
    end
    p_rdata <= parent_mem[req.p_raddr];
    c_rdata <= count_mem[req.c_raddr];
  end

  assign rsp.p_rdata = p_rdata;
  assign rsp.c_rdata = c_rdata;
  assign rsp.busy    = clr_busy;

endmodule

`default_nettype wire

### rtl/parent_tree_ancestor_lca_core.sv
// ---------------------------------------------------------------------------
// parent_tree_ancestor_lca_core: parent-pointer tree with ancestor queries
// inserts link a student under a teacher; list walks up to the root and
// returns every ancestor; common finds the nearest shared proper ancestor
// ---------------------------------------------------------------------------
//
//  channel       dir   handshake     payload
//  in_ch         in    valid/ready   func, node_a, node_b
//  out_ch        out   valid/ready   status, ancestor, last
//  cfg_wr_*      in    write enable  max_children (3 bits)
//
//  insert reads the parent and child count memories and then checks and
//  writes in S_INS, or goes straight to S_RESP when the ids alone reject it;
//  list walks up the parent memory into a chain buffer and then emits each
//  ancestor; common walks from node_a and then node_b, then merges both chains.
//  one command at a time; the next is taken once the result sits in the
//  output register. after reset a clearing pass runs over every entry of the
//  tree memories and no command is taken. a stalled output holds the engine.
// ---------------------------------------------------------------------------
`default_nettype none

module parent_tree_ancestor_lca_core (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cfg_wr_en,
  input  wire [ptlca_pkg::CNT_W-1:0]   cfg_wr_data,
  ptlca_in_if.sink                     in_ch,
  ptlca_out_if.source                  out_ch
);
  import ptlca_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_INS    = 8'b0000_0010,
    S_WSTART = 8'b0000_0100,
    S_WALK   = 8'b0000_1000,
    S_WDONE  = 8'b0001_0000,
    S_MERGE  = 8'b0010_0000,
    S_EMIT   = 8'b0100_0000,
    S_RESP   = 8'b1000_0000
  } state_t;

  typedef enum logic [1:0] {
    W_OK = 2'd0,
    W_NM = 2'd1,
    W_TD = 2'd2
  } walk_res_t;

  state_t    state, state_next;
  tree_req_t mem_req;
  tree_rsp_t mem_rsp;

  logic [CNT_W-1:0]    max_children;
  logic [FUNC_W-1:0]   func_q, func_q_next;
  logic [ID_W-1:0]     node_a_q, node_a_q_next;
  logic [ID_W-1:0]     node_b_q, node_b_q_next;
  logic                walk_sel, walk_sel_next;
  walk_res_t           wres, wres_next;
  walk_res_t           ra, ra_next;
  logic [CHAIN_AW-1:0] n, n_next;
  logic [CHAIN_AW-1:0] na, na_next;
  logic [CHAIN_AW-1:0] i, i_next;
  logic [CHAIN_AW-1:0] j, j_next;
  logic [CHAIN_AW-1:0] k, k_next;
  logic [STATUS_W-1:0] res_status, res_status_next;
  logic [ID_W-1:0]     res_anc, res_anc_next;

  // chain buffers
  logic [ID_W-1:0]     chain_a [CHAIN_SLOTS];
  logic [ID_W-1:0]     chain_b [CHAIN_SLOTS];
  logic                ch_we;
  logic [ID_W-1:0]     ch_wdata;
  logic [CHAIN_AW-1:0] ca_raddr, cb_raddr;
  logic [ID_W-1:0]     ca_q, cb_q;

  // output register
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [ID_W-1:0]     out_anc;
  logic                out_last;
  logic                out_load;
  logic [STATUS_W-1:0] load_status;
  logic [ID_W-1:0]     load_anc;
  logic                load_last;
  logic                out_free;

  logic                accept;
  logic [ID_W-1:0]     wnode;
  logic [ID_W-1:0]     p;

  ptlca_tree_mem u_tree_mem (
    .clk (clk),
    .rst (rst),
    .req (mem_req),
    .rsp (mem_rsp)
  );

  assign in_ch.ready     = (state == S_IDLE) && !mem_rsp.busy;
  assign accept          = in_ch.valid && in_ch.ready;
  assign out_free        = !out_valid || out_ch.ready;
  assign wnode           = walk_sel ? node_b_q : node_a_q;
  assign p               = mem_rsp.p_rdata;

  assign out_ch.valid    = out_valid;
  assign out_ch.status   = out_status;
  assign out_ch.ancestor = out_anc;
  assign out_ch.last     = out_last;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_children <= CNT_W'(3);
    end else if (cfg_wr_en) begin
      max_children <= cfg_wr_data;
    end
  end

  // sequencer
  always_comb begin
    state_next      = state;
    func_q_next     = func_q;
    node_a_q_next   = node_a_q;
    node_b_q_next   = node_b_q;
    walk_sel_next   = walk_sel;
    wres_next       = wres;
    ra_next         = ra;
    n_next          = n;
    na_next         = na;
    i_next          = i;
    j_next          = j;
    k_next          = k;
    res_status_next = res_status;
    res_anc_next    = res_anc;
    mem_req         = '0;
    ch_we           = 1'b0;
    ch_wdata        = p;
    ca_raddr        = i;
    cb_raddr        = j;
    out_load        = 1'b0;
    load_status     = res_status;
    load_anc        = res_anc;
    load_last       = 1'b1;

    case (state)
      S_IDLE: begin
        if (accept) begin
          func_q_next   = in_ch.func;
          node_a_q_next = in_ch.node_a;
          node_b_q_next = in_ch.node_b;
          case (in_ch.func)
            FUNC_INSERT: begin
              if (in_ch.node_a == '0 || in_ch.node_b <= in_ch.node_a) begin
                res_status_next = ST_REJECT;
                res_anc_next    = '0;
                state_next      = S_RESP;
              end else begin
                mem_req.p_raddr = in_ch.node_b;
                mem_req.c_raddr = in_ch.node_a;
                state_next      = S_INS;
              end
            end
            FUNC_LIST, FUNC_COMMON: begin
              walk_sel_next = 1'b0;
              state_next    = S_WSTART;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end

      // student must be unlinked, teacher below its limit
      S_INS: begin
        res_anc_next = '0;
        if (p == '0 && mem_rsp.c_rdata < max_children) begin
          mem_req.p_we    = 1'b1;
          mem_req.p_waddr = node_b_q;
          mem_req.p_wdata = node_a_q;
          mem_req.c_we    = 1'b1;
          mem_req.c_waddr = node_a_q;
          mem_req.c_wdata = mem_rsp.c_rdata + CNT_W'(1);
          res_status_next = ST_OK;
        end else begin
          res_status_next = ST_REJECT;
        end
        state_next = S_RESP;
      end

      // first step of a walk from node_a or node_b
      S_WSTART: begin
        n_next = '0;
        if (wnode == '0) begin
          wres_next  = W_NM;
          state_next = S_WDONE;
        end else if (wnode == ID_W'(1)) begin
          wres_next  = W_OK;
          state_next = S_WDONE;
        end else begin
          mem_req.p_raddr = wnode;
          state_next      = S_WALK;
        end
      end

      // one parent per cycle, the read address comes from the last read
      S_WALK: begin
        if (p == '0) begin
          wres_next  = W_NM;
          state_next = S_WDONE;
        end else if (n == CHAIN_AW'(MAX_DEPTH)) begin
          wres_next  = W_TD;
          state_next = S_WDONE;
        end else begin
          ch_we  = 1'b1;
          n_next = n + CHAIN_AW'(1);
          if (p == ID_W'(1)) begin
            wres_next  = W_OK;
            state_next = S_WDONE;
          end else begin
            mem_req.p_raddr = p;
          end
        end
      end

      S_WDONE: begin
        res_anc_next = '0;
        if (func_q == FUNC_LIST) begin
          if (wres == W_NM) begin
            res_status_next = ST_NOT_MEMBER;
            state_next      = S_RESP;
          end else if (wres == W_TD) begin
            res_status_next = ST_TOO_DEEP;
            state_next      = S_RESP;
          end else if (n == '0) begin
            res_status_next = ST_OK;
            state_next      = S_RESP;
          end else begin
            k_next     = '0;
            ca_raddr   = '0;
            state_next = S_EMIT;
          end
        end else if (!walk_sel) begin
          ra_next       = wres;
          na_next       = n;
          walk_sel_next = 1'b1;
          state_next    = S_WSTART;
        end else begin
          if (ra == W_TD || wres == W_TD) begin
            res_status_next = ST_TOO_DEEP;
            state_next      = S_RESP;
          end else if (ra == W_NM && wres == W_NM) begin
            res_status_next = ST_BOTH_NOT;
            state_next      = S_RESP;
          end else if (ra == W_NM) begin
            res_status_next = ST_A_NOT;
            state_next      = S_RESP;
          end else if (wres == W_NM) begin
            res_status_next = ST_B_NOT;
            state_next      = S_RESP;
          end else begin
            i_next     = '0;
            j_next     = '0;
            ca_raddr   = '0;
            cb_raddr   = '0;
            state_next = S_MERGE;
          end
        end
      end

      // both chains fall strictly, so a two-pointer merge finds the
      // earliest entry of the first chain that the second also holds
      S_MERGE: begin
        if (i == na || j == n) begin
          res_status_next = ST_NO_COMMON;
          res_anc_next    = '0;
          state_next      = S_RESP;
        end else if (ca_q == cb_q) begin
          res_status_next = ST_OK;
          res_anc_next    = ca_q;
          state_next      = S_RESP;
        end else if (ca_q > cb_q) begin
          i_next   = i + CHAIN_AW'(1);
          ca_raddr = i + CHAIN_AW'(1);
        end else begin
          j_next   = j + CHAIN_AW'(1);
          cb_raddr = j + CHAIN_AW'(1);
        end
      end

      // stream the ancestor list out of the first chain buffer
      S_EMIT: begin
        ca_raddr = k;
        if (out_free) begin
          out_load    = 1'b1;
          load_status = ST_OK;
          load_anc    = ca_q;
          load_last   = (k + CHAIN_AW'(1)) == n;
          if (load_last) begin
            state_next = S_IDLE;
          end else begin
            k_next   = k + CHAIN_AW'(1);
            ca_raddr = k + CHAIN_AW'(1);
          end
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    func_q     <= func_q_next;
    node_a_q   <= node_a_q_next;
    node_b_q   <= node_b_q_next;
    walk_sel   <= walk_sel_next;
    wres       <= wres_next;
    ra         <= ra_next;
    n          <= n_next;
    na         <= na_next;
    i          <= i_next;
    j          <= j_next;
    k          <= k_next;
    res_status <= res_status_next;
    res_anc    <= res_anc_next;
    if (out_load) begin
      out_status <= load_status;
      out_anc    <= load_anc;
      out_last   <= load_last;
    end
  end

  // chain buffers: written during a walk, with registered reads
  always_ff @(posedge clk) begin
    if (ch_we && !walk_sel) begin
      chain_a[n] <= ch_wdata;
    end
    if (ch_we && walk_sel) begin
      chain_b[n] <= ch_wdata;
    end
    ca_q <= chain_a[ca_raddr];
    cb_q <= chain_b[cb_raddr];
  end

  // a link always points from a larger id to a nonzero smaller one
  a_link_order: assert property (@(posedge clk) disable iff (rst)
    mem_req.p_we |-> (mem_req.p_wdata != '0 && mem_req.p_waddr > mem_req.p_wdata))
    else $error("link written out of order");

  // merge pointers never run past the chain lengths
  a_merge_bounds: assert property (@(posedge clk) disable iff (rst)
    state == S_MERGE |-> (i <= na && j <= n))
    else $error("merge pointer past chain end");

  // list output index stays inside the collected chain
  a_emit_bounds: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT |-> k < n)
    else $error("emit index past chain end");

  // the engine sits idle when the clearing pass ends
  a_clear_idle: assert property (@(posedge clk) disable iff (rst)
    $fell(mem_rsp.busy) |-> state == S_IDLE)
    else $error("engine active during clearing pass");

endmodule

`default_nettype wire
